// ===== rtl/sha256_pkg.sv =====
// SHA-256 hasher package: word width, round constants and initial hash.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package sha256_pkg;

	localparam int WORD_W  = 32;
	localparam int COUNT_W = 3;
	localparam int INDEX_W = 3;

	localparam logic [0:7][WORD_W-1:0] HASH_IV = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [0:63][WORD_W-1:0] ROUND_K = {
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x, input int n);
		rotr = (x >> n) | (x << (WORD_W - n));
	endfunction

	function automatic logic [WORD_W-1:0] big_sigma0(input logic [WORD_W-1:0] x);
		big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [WORD_W-1:0] big_sigma1(input logic [WORD_W-1:0] x);
		big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [WORD_W-1:0] small_sigma0(input logic [WORD_W-1:0] x);
		small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [WORD_W-1:0] small_sigma1(input logic [WORD_W-1:0] x);
		small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage

// ===== rtl/sha256_if.sv =====
// Valid/ready channel interfaces for the SHA-256 hasher: message in, digest out.
// Depends on sha256_pkg for field widths.
`timescale 1ns / 1ps

interface sha256_in_if;
	logic                             valid;
	logic                             ready;
	logic [sha256_pkg::WORD_W-1:0]    message_word;
	logic [sha256_pkg::COUNT_W-1:0]   byte_count;
	logic                             last_word;

	modport source (output valid, message_word, byte_count, last_word, input ready);
	modport sink   (input valid, message_word, byte_count, last_word, output ready);
endinterface

interface sha256_out_if;
	logic                             valid;
	logic                             ready;
	logic [sha256_pkg::WORD_W-1:0]    digest_word;
	logic [sha256_pkg::INDEX_W-1:0]   digest_index;
	logic                             digest_done;

	modport source (output valid, digest_word, digest_index, digest_done, input ready);
	modport sink   (input valid, digest_word, digest_index, digest_done, output ready);
endinterface

// ===== rtl/sha256_message_hash_top.sv =====
// SHA-256 message hasher top level: padding sequencer, round unit, digest output.
// Depends on sha256_pkg and the channel interfaces in sha256_if.sv.
`timescale 1ns / 1ps

// A message enters one big-endian word per request. When the sixteenth word of a
// block lands, one round unit runs 64 rounds, one per cycle, then ST_HADD adds
// the result into the hash. After the last word the sequencer appends padding
// and the length one word per cycle (with a second compression when the length
// spills into an extra block), then presents the eight digest words in order,
// one per accepted request. The input is not ready from a block's last word
// until its compression is done, nor while padding or the digest is in flight.
// The hash returns to its initial value after the eighth digest word is taken.
module sha256_message_hash_top (
	input  logic         clk,
	input  logic         arst_n,
	sha256_in_if.sink    msg,
	sha256_out_if.source digest
);
	import sha256_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_PAD   = 5'b00010,
		ST_ROUND = 5'b00100,
		ST_HADD  = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	state_t              state_q, state_d;
	logic [3:0]          slot_q;
	logic [5:0]          round_q;
	logic [63:0]         bits_q;
	logic [WORD_W-1:0]   hash_q [8];
	logic [WORD_W-1:0]   var_q [8];
	logic [WORD_W-1:0]   sched_q [16];
	logic [WORD_W-1:0]   first_word_q;
	logic                pend_first_q;
	logic                hi_done_q;
	logic                msg_end_q;
	logic [INDEX_W-1:0]  out_idx_q;

	logic                in_fire, out_fire;
	logic                full_word;
	logic [1:0]          cnt;
	logic [WORD_W-1:0]   keep_mask, pad_word;
	logic                push_en;
	logic [WORD_W-1:0]   push_word;
	logic                block_full;
	logic [WORD_W-1:0]   w_next, t1, t2;

	assign msg.ready    = (state_q == ST_IDLE);
	assign in_fire      = msg.valid && msg.ready;
	assign digest.valid = (state_q == ST_OUT);
	assign out_fire     = digest.valid && digest.ready;

	assign digest.digest_word  = hash_q[out_idx_q];
	assign digest.digest_index = out_idx_q;
	assign digest.digest_done  = (out_idx_q == INDEX_W'(7));

	// counts above four, and short words not marked last, act as full words
	assign full_word = !msg.last_word || (msg.byte_count >= COUNT_W'(4));
	assign cnt       = msg.byte_count[1:0];
	assign keep_mask = ~(32'hFFFF_FFFF >> {cnt, 3'b000});
	assign pad_word  = (msg.message_word & keep_mask) | (32'h8000_0000 >> {cnt, 3'b000});

	// word pushed into the schedule line this cycle
	always_comb begin
		push_en   = 1'b0;
		push_word = msg.message_word;
		case (state_q)
			ST_IDLE: begin
				push_en = in_fire && full_word;
			end
			ST_PAD: begin
				push_en = 1'b1;
				if (pend_first_q) begin
					push_word = first_word_q;
				end else if (hi_done_q) begin
					push_word = bits_q[31:0];
				end else if (slot_q == 4'd14) begin
					push_word = bits_q[63:32];
				end else begin
					push_word = '0;
				end
			end
			default: begin
				push_en = 1'b0;
			end
		endcase
	end

	assign block_full = push_en && (slot_q == 4'd15);

	// message schedule expansion and one compression round
	assign w_next = small_sigma1(sched_q[14]) + sched_q[9] + small_sigma0(sched_q[1]) + sched_q[0];
	assign t1 = var_q[7] + big_sigma1(var_q[4]) + ((var_q[4] & var_q[5]) ^ (~var_q[4] & var_q[6]))
		+ ROUND_K[round_q] + sched_q[0];
	assign t2 = big_sigma0(var_q[0])
		+ ((var_q[0] & var_q[1]) ^ (var_q[0] & var_q[2]) ^ (var_q[1] & var_q[2]));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (block_full) begin
					state_d = ST_ROUND;
				end else if (in_fire && msg.last_word) begin
					state_d = ST_PAD;
				end
			end
			ST_PAD: begin
				if (block_full) begin
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: begin
				if (round_q == 6'd63) begin
					state_d = ST_HADD;
				end
			end
			ST_HADD: begin
				if (msg_end_q && hi_done_q) begin
					state_d = ST_OUT;
				end else if (msg_end_q) begin
					state_d = ST_PAD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_OUT: begin
				if (out_fire && digest.digest_done) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			slot_q       <= '0;
			round_q      <= '0;
			bits_q       <= '0;
			pend_first_q <= 1'b0;
			hi_done_q    <= 1'b0;
			msg_end_q    <= 1'b0;
			out_idx_q    <= '0;
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= HASH_IV[i];
			end
		end else begin
			state_q <= state_d;
			if (push_en) begin
				slot_q <= slot_q + 4'd1;
			end
			if (in_fire) begin
				bits_q    <= bits_q + (full_word ? 64'd32 : 64'({cnt, 3'b000}));
				msg_end_q <= msg.last_word;
			end
			if (in_fire && msg.last_word) begin
				pend_first_q <= 1'b1;
			end else if (state_q == ST_PAD) begin
				pend_first_q <= 1'b0;
				if (!pend_first_q && slot_q == 4'd14 && !hi_done_q) begin
					hi_done_q <= 1'b1;
				end
			end
			if (state_q == ST_ROUND) begin
				round_q <= round_q + 6'd1;
			end
			if (state_q == ST_HADD) begin
				for (int i = 0; i < 8; i++) begin
					hash_q[i] <= hash_q[i] + var_q[i];
				end
			end
			if (out_fire) begin
				out_idx_q <= out_idx_q + INDEX_W'(1);
				if (digest.digest_done) begin
					for (int i = 0; i < 8; i++) begin
						hash_q[i] <= HASH_IV[i];
					end
					bits_q    <= '0;
					hi_done_q <= 1'b0;
					msg_end_q <= 1'b0;
				end
			end
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		if (in_fire && msg.last_word) begin
			first_word_q <= full_word ? 32'h8000_0000 : pad_word;
		end
		if (push_en || state_q == ST_ROUND) begin
			for (int i = 0; i < 15; i++) begin
				sched_q[i] <= sched_q[i+1];
			end
			sched_q[15] <= (state_q == ST_ROUND) ? w_next : push_word;
		end
		if (block_full) begin
			for (int i = 0; i < 8; i++) begin
				var_q[i] <= hash_q[i];
			end
		end else if (state_q == ST_ROUND) begin
			var_q[7] <= var_q[6];
			var_q[6] <= var_q[5];
			var_q[5] <= var_q[4];
			var_q[4] <= var_q[3] + t1;
			var_q[3] <= var_q[2];
			var_q[2] <= var_q[1];
			var_q[1] <= var_q[0];
			var_q[0] <= t1 + t2;
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(msg.ready && digest.valid))
		else $error("input ready while digest is presented");

	a_round_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_ROUND) |-> (round_q == 6'd0))
		else $error("round counter not at rest outside compression");

	a_slot_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |-> (slot_q == 4'd0))
		else $error("compression started on a partial block");

	a_reopen: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && digest.digest_done) |=> (msg.ready && bits_q == 64'd0))
		else $error("hasher not rearmed after final digest word");

endmodule

// ===== dv/sha256_digest_compare.sv =====
// Digest predictor and comparator for the SHA-256 message hasher.
// Watches the request and digest channels (sha256_if.sv); uses widths from sha256_pkg.
`timescale 1ns / 1ps

module sha256_digest_compare (
	input  logic  clk,
	input  logic  arst_n,
	sha256_in_if  msg_mon,
	sha256_out_if dig_mon,
	output int    fail_count,
	output int    pending
);

	typedef struct packed {
		logic [sha256_pkg::WORD_W-1:0]  word;
		logic [sha256_pkg::INDEX_W-1:0] index;
		logic                           done;
	} digest_beat_t;

	localparam logic [0:7][31:0] START_HASH = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [0:63][31:0] ROUND_ADD = {
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	logic [31:0]  hash_state [8];
	logic [31:0]  block_words [16];
	logic [63:0]  bit_length;
	int           fill_slot;
	digest_beat_t digest_queue [$];

	function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic void absorb_block();
		logic [31:0] sched [64];
		logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
		for (int r = 0; r < 16; r++)
			sched[r] = block_words[r];
		for (int r = 16; r < 64; r++) begin
			sched[r] = (ror32(sched[r-2], 17) ^ ror32(sched[r-2], 19) ^ (sched[r-2] >> 10))
				+ sched[r-7]
				+ (ror32(sched[r-15], 7) ^ ror32(sched[r-15], 18) ^ (sched[r-15] >> 3))
				+ sched[r-16];
		end
		a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
		e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
		for (int r = 0; r < 64; r++) begin
			t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
				+ ROUND_ADD[r] + sched[r];
			t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1;
			d = c; c = b; b = a; a = t1 + t2;
		end
		hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
		hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
	endfunction

	function automatic void push_word(input logic [31:0] w);
		block_words[fill_slot] = w;
		fill_slot++;
		if (fill_slot == 16) begin
			absorb_block();
			fill_slot = 0;
		end
	endfunction

	function automatic void restart_message();
		for (int k = 0; k < 8; k++)
			hash_state[k] = START_HASH[k];
		bit_length = '0;
		fill_slot = 0;
	endfunction

	function automatic void take_request(input logic [31:0] word, input logic [2:0] count,
		input logic last);
		int          nbytes;
		logic [31:0] tail;
		digest_beat_t beat;
		// counts above four, and any count on a word not marked last, mean a full word
		nbytes = (count > 4 || !last) ? 4 : int'(count);
		bit_length += 64'(nbytes * 8);
		if (!last) begin
			push_word(word);
			return;
		end
		if (nbytes == 4) begin
			push_word(word);
			tail = 32'h8000_0000;
		end else begin
			// clear stray bytes, then the 0x80 marker right after the valid ones
			tail = (word & ~(32'hffff_ffff >> (8 * nbytes))) | (32'h80 << (24 - 8 * nbytes));
		end
		push_word(tail);
		// no room left for the length: fill out and compress an extra block
		if (fill_slot > 14) begin
			while (fill_slot != 0)
				push_word('0);
		end
		while (fill_slot < 14)
			push_word('0);
		push_word(bit_length[63:32]);
		push_word(bit_length[31:0]);
		for (int k = 0; k < 8; k++) begin
			beat.word = hash_state[k];
			beat.index = k[sha256_pkg::INDEX_W-1:0];
			beat.done = (k == 7);
			digest_queue.insert(digest_queue.size(), beat);
		end
		restart_message();
	endfunction

	always @(posedge clk or negedge arst_n) begin
		digest_beat_t want;
		if (!arst_n) begin
			restart_message();
			digest_queue.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (dig_mon.valid && dig_mon.ready) begin
				if (digest_queue.size() == 0) begin
					$error("digest word (index %0d) with nothing expected", dig_mon.digest_index);
					fail_count++;
				end else begin
					want = digest_queue.pop_front();
					if (dig_mon.digest_word !== want.word) begin
						$error("digest_word: expected %h, got %h", want.word, dig_mon.digest_word);
						fail_count++;
					end
					if (dig_mon.digest_index !== want.index) begin
						$error("digest_index: expected %0d, got %0d", want.index,
							dig_mon.digest_index);
						fail_count++;
					end
					if (dig_mon.digest_done !== want.done) begin
						$error("digest_done: expected %0d, got %0d", want.done,
							dig_mon.digest_done);
						fail_count++;
					end
				end
			end
			if (msg_mon.valid && msg_mon.ready)
				take_request(msg_mon.message_word, msg_mon.byte_count, msg_mon.last_word);
			pending = digest_queue.size();
		end
	end

endmodule

// ===== dv/tb_sha256_message_hash_top.sv =====
// Testbench top for sha256_message_hash_top: clock, reset, message requests and verdict.
// Depends on sha256_pkg, sha256_if.sv, the RTL top and sha256_digest_compare.
`timescale 1ns / 1ps

module tb_sha256_message_hash_top;

	localparam int WORD_TARGET = 270;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 200;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   cycle_count;
	int   words_sent;
	int   idle_mode;

	sha256_in_if  msg_if ();
	sha256_out_if dig_if ();

	sha256_message_hash_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_if),
		.digest (dig_if)
	);

	sha256_digest_compare i_compare (
		.clk        (clk),
		.arst_n     (arst_n),
		.msg_mon    (msg_if),
		.dig_mon    (dig_if),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// mode 0: back to back, 1: full gaps, 2: short gaps
	function automatic int draw_gap();
		case (idle_mode)
			0: return 0;
			1: return $urandom_range(0, 18);
			default: return $urandom_range(0, 3);
		endcase
	endfunction

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_request(input logic [sha256_pkg::WORD_W-1:0] word,
		input logic [sha256_pkg::COUNT_W-1:0] count, input logic last);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			msg_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		msg_if.valid <= 1'b1;
		msg_if.message_word <= word;
		msg_if.byte_count <= count;
		msg_if.last_word <= last;
		do @(posedge clk); while (!msg_if.ready);
		@(negedge clk);
		words_sent++;
	endtask

	task automatic send_message(input int body_len, input bit noisy);
		logic [2:0] cnt;
		for (int i = 0; i < body_len; i++) begin
			cnt = 3'd4;
			if (noisy && $urandom_range(0, 2) == 0)
				cnt = 3'($urandom_range(0, 7));
			send_request(pick_word(), cnt, 1'b0);
		end
		cnt = 3'($urandom_range(0, 7));
		send_request(pick_word(), cnt, 1'b1);
	endtask

	// digest side: random stall before each word, then hold ready until taken
	initial begin
		int gap;
		dig_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			gap = draw_gap();
			if (gap > 0) begin
				dig_if.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			dig_if.ready <= 1'b1;
			do @(posedge clk); while (!dig_if.valid);
			@(negedge clk);
		end
	end

	initial begin
		int body_len;
		cycle_count = 0;
		words_sent = 0;
		idle_mode = 1;
		arst_n = 1'b0;
		msg_if.valid = 1'b0;
		msg_if.message_word = '0;
		msg_if.byte_count = '0;
		msg_if.last_word = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty message, stray bytes in the final word
		send_request(32'hdead_beef, 3'd0, 1'b1);
		send_request(32'h6162_63ff, 3'd3, 1'b1);
		// counts above four on a final word, then a one-byte final word
		idle_mode = 2;
		send_request(32'hffff_ffff, 3'd5, 1'b1);
		send_request(32'h0000_0000, 3'd6, 1'b1);
		send_request(32'h8000_0001, 3'd7, 1'b1);
		send_request(32'hff00_ff00, 3'd1, 1'b1);
		// short word not marked last counts as four bytes
		idle_mode = 1;
		send_request(32'h1234_5678, 3'd1, 1'b0);
		send_request(32'ha5a5_a5a5, 3'd2, 1'b1);
		// marker lands in slot 14: length spills into an extra block
		idle_mode = 0;
		for (int i = 0; i < 14; i++)
			send_request(pick_word(), 3'd4, 1'b0);
		send_request(pick_word(), 3'd0, 1'b1);

		while (words_sent < WORD_TARGET) begin
			idle_mode = $urandom_range(0, 2);
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: body_len = $urandom_range(0, 3);
				5, 6, 7: body_len = $urandom_range(12, 17);
				8: body_len = $urandom_range(28, 33);
				default: body_len = $urandom_range(0, 40);
			endcase
			send_message(body_len, $urandom_range(0, 4) == 0);
		end
		msg_if.valid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
